FILE: rtl/core/stpq_pkg.sv
`timescale 1ns / 1ps

package stpq_pkg;

  // default queue depth
  localparam int unsigned QUEUE_DEPTH = 256;

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // tier codes
  localparam logic [1:0] TIER_NONE   = 2'd0;
  localparam logic [1:0] TIER_LETTER = 2'd1;
  localparam logic [1:0] TIER_OTHER  = 2'd2;
  localparam logic [1:0] TIER_VOWEL  = 2'd3;

  // input beat
  typedef struct packed {
    logic       cmd;
    logic [7:0] in_char;
  } req_t;

  // result beat
  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] out_tier;
    logic [1:0] status;
    logic [8:0] occupancy;
  } res_t;

  // one held entry
  typedef struct packed {
    logic [1:0] tier;
    logic [7:0] char_val;
  } entry_t;

  // broadcast control for the cell row
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

  // vowels tier 3, other letters tier 1, anything else tier 2
  function automatic logic [1:0] tier_of(input logic [7:0] c);
    logic [7:0] lower;
    logic       letter;
    logic       vowel;
    lower  = c | 8'h20;
    letter = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    vowel  = (lower == 8'h61) || (lower == 8'h65) || (lower == 8'h69) ||
             (lower == 8'h6f) || (lower == 8'h75);
    if (!letter) begin
      return TIER_OTHER;
    end else if (vowel) begin
      return TIER_VOWEL;
    end
    return TIER_LETTER;
  endfunction

endpackage

FILE: rtl/core/stpq_cell.sv
`timescale 1ns / 1ps

module stpq_cell (
  input  logic                clk_i,
  input  stpq_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic                left_ge_i,
  input  stpq_pkg::entry_t    left_entry_i,
  input  stpq_pkg::entry_t    right_entry_i,
  output stpq_pkg::entry_t    entry_o,
  output logic                ge_o
);
  import stpq_pkg::*;

  entry_t entry_q, entry_d;

  // held entry ranks at or above the incoming one
  assign ge_o = valid_i && (entry_q.tier >= ctrl_i.new_entry.tier);

  // keep, take the new entry, shift right on push, shift left on pop
  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.push) begin
      if (ge_o) begin
        entry_d = entry_q;
      end else if (left_ge_i) begin
        entry_d = ctrl_i.new_entry;
      end else begin
        entry_d = left_entry_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/core/stable_tiered_priority_queue_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// command   in         start high, busy low      req_i  (cmd, in_char)
// result    out        done_o one-cycle strobe   res_o  (out_char, out_tier, status, occupancy)
//
// one command per cycle; busy stays low and the result strobes on the next cycle
// a push or pop moves every cell of the row at once; on a push each cell compares its tier
// reset clears the entry count; cell contents are don't-care until written
// results cannot be held off: each one is on res_o for a single cycle

module stable_tiered_priority_queue_top #(
  parameter int unsigned QueueDepth = stpq_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  stpq_pkg::req_t req_i,
  output logic           done_o,
  output stpq_pkg::res_t res_o
);
  import stpq_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  res_t            res_q, res_d;
  cell_ctrl_t      ctrl;
  logic            accept, is_push, is_pop, full, empty;
  logic [1:0]      new_tier;

  entry_t          cell_entry [QueueDepth];
  logic            cell_ge    [QueueDepth];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_push = accept && (req_i.cmd == CMD_PUSH);
  assign is_pop  = accept && (req_i.cmd == CMD_POP);
  assign full    = (count_q == CntW'(QueueDepth));
  assign empty   = (count_q == '0);
  assign new_tier = tier_of(req_i.in_char);

  // broadcast to the cells
  always_comb begin
    ctrl.push               = is_push && !full;
    ctrl.pop                = is_pop && !empty;
    ctrl.new_entry.tier     = new_tier;
    ctrl.new_entry.char_val = req_i.in_char;
  end

  // row of cells, front at index 0
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_ge;
    if (i == 0) begin : g_first
      assign left_entry = ctrl.new_entry;
      assign left_ge    = 1'b1;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_ge    = cell_ge[i-1];
    end
    if (i == QueueDepth - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end
    stpq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .valid_i       (count_q > CntW'(i)),
      .left_ge_i     (left_ge),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (cell_entry[i]),
      .ge_o          (cell_ge[i])
    );
  end

  // count and result
  always_comb begin
    count_d = count_q;
    res_d   = '0;
    if (ctrl.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CntW'(1);
    end
    if (is_push) begin
      res_d.out_tier = new_tier;
      res_d.status   = full ? STATUS_FULL : STATUS_OK;
    end else if (is_pop) begin
      if (empty) begin
        res_d.out_tier = TIER_NONE;
        res_d.status   = STATUS_EMPTY;
      end else begin
        res_d.out_char = cell_entry[0].char_val;
        res_d.out_tier = cell_entry[0].tier;
        res_d.status   = STATUS_OK;
      end
    end
    res_d.occupancy = 9'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
